FILE: rtl/core/fat_pkg.sv
// ----------------------------------------------------------------------------
// fat_pkg
// Shared types and constants of the four-anchor trilateration block.
// ----------------------------------------------------------------------------
package fat_pkg;

    localparam int NUM_ANCHORS  = 4;
    localparam int NUM_TRI      = 4;
    localparam int NUM_LANES    = 2 * NUM_TRI;
    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int POS_BITS     = 32;

    localparam logic signed [POS_BITS-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_BITS-1:0] POS_MIN = 32'sh8000_0000;

    // anchor triples ABC, ABD, ACD, BCD as (p1, p2, p3)
    localparam int TRI_P1 [NUM_TRI] = '{0, 0, 0, 1};
    localparam int TRI_P2 [NUM_TRI] = '{1, 1, 2, 2};
    localparam int TRI_P3 [NUM_TRI] = '{2, 3, 3, 3};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5,
        REG_D_X = 3'd6,
        REG_D_Y = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic                       degenerate;
        logic                       overflow;
    } t_res;

endpackage

FILE: rtl/core/fat_in_if.sv
// ----------------------------------------------------------------------------
// fat_in_if
// Distance word channel: four measured distances, valid/ready.
// ----------------------------------------------------------------------------
interface fat_in_if #(
    parameter int DIST_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] dist_a;
    logic [DIST_BITS-1:0] dist_b;
    logic [DIST_BITS-1:0] dist_c;
    logic [DIST_BITS-1:0] dist_d;

    modport source (output valid, dist_a, dist_b, dist_c, dist_d, input ready);
    modport sink   (input valid, dist_a, dist_b, dist_c, dist_d, output ready);
endinterface

FILE: rtl/core/fat_out_if.sv
// ----------------------------------------------------------------------------
// fat_out_if
// Position word channel: Q.8 position and status flags, valid/ready.
// ----------------------------------------------------------------------------
interface fat_out_if import fat_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic                       degenerate;
    logic                       overflow;

    modport source (output valid, pos_x, pos_y, degenerate, overflow, input ready);
    modport sink   (input valid, pos_x, pos_y, degenerate, overflow, output ready);
endinterface

FILE: rtl/core/fat_div.sv
// ----------------------------------------------------------------------------
// fat_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module fat_div #(
    parameter int NQ_BITS  = 61,
    parameter int DEN_BITS = 37
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NQ_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NQ_BITS-1:0]  o_quo
);

    // dividend shifts out at the top, quotient bits shift in at the bottom
    logic [DEN_BITS-1:0] r_rem [NQ_BITS];
    logic [NQ_BITS-1:0]  r_num [NQ_BITS];
    logic [DEN_BITS-1:0] r_den [NQ_BITS];

    logic [DEN_BITS-1:0] w_rem [NQ_BITS+1];
    logic [NQ_BITS-1:0]  w_num [NQ_BITS+1];
    logic [DEN_BITS-1:0] w_den [NQ_BITS+1];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < NQ_BITS; k++) begin : g_stage
        logic [DEN_BITS:0]   w_t;
        logic                w_ge;
        logic [DEN_BITS-1:0] n_rem;
        logic [NQ_BITS-1:0]  n_num;

        always_comb begin
            w_t   = {w_rem[k], w_num[k][NQ_BITS-1]};
            w_ge  = (w_t >= {1'b0, w_den[k]});
            n_rem = w_ge ? DEN_BITS'(w_t - {1'b0, w_den[k]}) : DEN_BITS'(w_t);
            n_num = {w_num[k][NQ_BITS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= n_num;
                r_den[k] <= w_den[k];
            end
        end

        assign w_rem[k+1] = r_rem[k];
        assign w_num[k+1] = r_num[k];
        assign w_den[k+1] = r_den[k];
    end

    assign o_quo = w_num[NQ_BITS];

endmodule

FILE: rtl/core/four_anchor_trilateration.sv
// ----------------------------------------------------------------------------
// four_anchor_trilateration
// Averaged 2D position from four anchor distances, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one distance word per clock while input ready is high and returns one
// position word per word, in order. Most of the pipeline depth lies in the
// eight bit-per-stage restoring dividers, one per triple and axis. A two-entry
// output buffer keeps input ready high while one result waits. Anchor
// registers may only be written while no word is in flight.
module four_anchor_trilateration
    import fat_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DIST_BITS  = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fat_in_if.sink                  i_dist,
    fat_out_if.source               o_pos,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_wdata
);

    localparam int C   = COORD_BITS;
    localparam int M   = (2 * COORD_BITS > 2 * DIST_BITS) ? 2 * COORD_BITS : 2 * DIST_BITS;
    localparam int C2  = 2 * COORD_BITS;
    localparam int D2  = 2 * DIST_BITS;
    localparam int AW  = C + 2;
    localparam int BW  = M + 2;
    localparam int PW  = BW + AW;
    localparam int NW  = PW + 1;
    localparam int DTW = 2 * AW;
    localparam int DW  = 2 * AW + 1;
    localparam int NQ  = NW + FRAC_BITS;
    localparam int QW  = NQ + 1;
    localparam int SW  = NQ + 3;
    localparam int EW  = (SW > 33) ? SW : 33;
    localparam int NST = NQ + 10;

    localparam logic [EW-1:0] LIM_P = EW'(33'h0_7FFF_FFFF);
    localparam logic [EW-1:0] LIM_N = EW'(33'h0_8000_0000);

    // anchor registers
    logic signed [C-1:0] r_ax [NUM_ANCHORS];
    logic signed [C-1:0] r_ay [NUM_ANCHORS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ANCHORS; i++) begin
                r_ax[i] <= '0;
                r_ay[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_A_X: r_ax[0] <= $signed(i_cfg_wdata);
                REG_A_Y: r_ay[0] <= $signed(i_cfg_wdata);
                REG_B_X: r_ax[1] <= $signed(i_cfg_wdata);
                REG_B_Y: r_ay[1] <= $signed(i_cfg_wdata);
                REG_C_X: r_ax[2] <= $signed(i_cfg_wdata);
                REG_C_Y: r_ay[2] <= $signed(i_cfg_wdata);
                REG_D_X: r_ax[3] <= $signed(i_cfg_wdata);
                REG_D_Y: r_ay[3] <= $signed(i_cfg_wdata);
            endcase
        end
    end

    // pipeline control: all stages move together unless the skid is full
    logic           w_en;
    logic [NST-1:0] r_v;
    logic           r_o_v;
    logic           r_k_v;
    logic           w_push;
    logic           w_pop;

    assign w_en         = ~r_k_v;
    assign i_dist.ready = w_en;
    assign w_push       = w_en & r_v[NST-1];
    assign w_pop        = r_o_v & o_pos.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], i_dist.valid};
        end
    end

    // datapath registers
    logic [DIST_BITS-1:0] r_d   [NUM_ANCHORS];
    logic [D2-1:0]        r_dsq [NUM_ANCHORS];
    logic signed [C2-1:0] r_xsq [NUM_ANCHORS];
    logic signed [C2-1:0] r_ysq [NUM_ANCHORS];

    logic signed [AW-1:0] r_a11_s1 [NUM_TRI];
    logic signed [AW-1:0] r_a12_s1 [NUM_TRI];
    logic signed [AW-1:0] r_a21_s1 [NUM_TRI];
    logic signed [AW-1:0] r_a22_s1 [NUM_TRI];
    logic signed [AW-1:0] r_a11_s2 [NUM_TRI];
    logic signed [AW-1:0] r_a12_s2 [NUM_TRI];
    logic signed [AW-1:0] r_a21_s2 [NUM_TRI];
    logic signed [AW-1:0] r_a22_s2 [NUM_TRI];
    logic signed [BW-1:0] r_b1 [NUM_TRI];
    logic signed [BW-1:0] r_b2 [NUM_TRI];

    logic signed [PW-1:0]  r_pxa [NUM_TRI];
    logic signed [PW-1:0]  r_pxb [NUM_TRI];
    logic signed [PW-1:0]  r_pya [NUM_TRI];
    logic signed [PW-1:0]  r_pyb [NUM_TRI];
    logic signed [DTW-1:0] r_pda [NUM_TRI];
    logic signed [DTW-1:0] r_pdb [NUM_TRI];

    logic signed [NW-1:0] r_nx  [NUM_TRI];
    logic signed [NW-1:0] r_ny  [NUM_TRI];
    logic signed [DW-1:0] r_det [NUM_TRI];

    logic [NQ-1:0]        r_dvd [NUM_LANES];
    logic [DW-1:0]        r_dvs [NUM_TRI];
    logic [NUM_LANES-1:0] r_sg;
    logic                 r_dg;

    logic [NUM_LANES-1:0] r_sgp [NQ];
    logic [NQ-1:0]        r_dgp;
    logic [NQ-1:0]        w_quo [NUM_LANES];

    logic signed [QW-1:0] r_q  [NUM_LANES];
    logic signed [SW-1:0] r_s1 [2][2];
    logic signed [SW-1:0] r_s2 [2];
    logic [SW-1:0]        r_mg [2];
    logic [1:0]           r_ng;
    logic                 r_dg_q;
    logic                 r_dg_s1;
    logic                 r_dg_s2;
    logic                 r_dg_f1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= i_dist.dist_a;
            r_d[1] <= i_dist.dist_b;
            r_d[2] <= i_dist.dist_c;
            r_d[3] <= i_dist.dist_d;

            for (int i = 0; i < NUM_ANCHORS; i++) begin
                r_dsq[i] <= D2'(r_d[i]) * D2'(r_d[i]);
                r_xsq[i] <= C2'(r_ax[i]) * C2'(r_ax[i]);
                r_ysq[i] <= C2'(r_ay[i]) * C2'(r_ay[i]);
            end

            for (int t = 0; t < NUM_TRI; t++) begin
                r_a11_s1[t] <= (AW'(r_ax[TRI_P1[t]]) - AW'(r_ax[TRI_P3[t]])) <<< 1;
                r_a12_s1[t] <= (AW'(r_ay[TRI_P1[t]]) - AW'(r_ay[TRI_P3[t]])) <<< 1;
                r_a21_s1[t] <= (AW'(r_ax[TRI_P2[t]]) - AW'(r_ax[TRI_P3[t]])) <<< 1;
                r_a22_s1[t] <= (AW'(r_ay[TRI_P2[t]]) - AW'(r_ay[TRI_P3[t]])) <<< 1;

                r_a11_s2[t] <= r_a11_s1[t];
                r_a12_s2[t] <= r_a12_s1[t];
                r_a21_s2[t] <= r_a21_s1[t];
                r_a22_s2[t] <= r_a22_s1[t];
                r_b1[t] <= BW'(r_xsq[TRI_P1[t]]) - BW'(r_xsq[TRI_P3[t]])
                         + BW'(r_ysq[TRI_P1[t]]) - BW'(r_ysq[TRI_P3[t]])
                         + $signed(BW'(r_dsq[TRI_P3[t]])) - $signed(BW'(r_dsq[TRI_P1[t]]));
                r_b2[t] <= BW'(r_xsq[TRI_P2[t]]) - BW'(r_xsq[TRI_P3[t]])
                         + BW'(r_ysq[TRI_P2[t]]) - BW'(r_ysq[TRI_P3[t]])
                         + $signed(BW'(r_dsq[TRI_P3[t]])) - $signed(BW'(r_dsq[TRI_P2[t]]));

                r_pxa[t] <= PW'(r_b1[t]) * PW'(r_a22_s2[t]);
                r_pxb[t] <= PW'(r_a12_s2[t]) * PW'(r_b2[t]);
                r_pya[t] <= PW'(r_a11_s2[t]) * PW'(r_b2[t]);
                r_pyb[t] <= PW'(r_b1[t]) * PW'(r_a21_s2[t]);
                r_pda[t] <= DTW'(r_a11_s2[t]) * DTW'(r_a22_s2[t]);
                r_pdb[t] <= DTW'(r_a12_s2[t]) * DTW'(r_a21_s2[t]);

                r_nx[t]  <= NW'(r_pxa[t]) - NW'(r_pxb[t]);
                r_ny[t]  <= NW'(r_pya[t]) - NW'(r_pyb[t]);
                r_det[t] <= DW'(r_pda[t]) - DW'(r_pdb[t]);

                // magnitudes and signs for the unsigned dividers
                r_sg[2*t]     <= r_nx[t][NW-1] ^ r_det[t][DW-1];
                r_sg[2*t+1]   <= r_ny[t][NW-1] ^ r_det[t][DW-1];
                r_dvd[2*t]    <= NQ'($unsigned(r_nx[t][NW-1] ? -r_nx[t] : r_nx[t]))
                                 << FRAC_BITS;
                r_dvd[2*t+1]  <= NQ'($unsigned(r_ny[t][NW-1] ? -r_ny[t] : r_ny[t]))
                                 << FRAC_BITS;
                r_dvs[t]      <= $unsigned(r_det[t][DW-1] ? -r_det[t] : r_det[t]);
            end
            r_dg <= (r_det[0] == '0) | (r_det[1] == '0)
                  | (r_det[2] == '0) | (r_det[3] == '0);

            for (int k = 0; k < NQ; k++) begin
                r_sgp[k] <= (k == 0) ? r_sg : r_sgp[(k == 0) ? 0 : k-1];
            end
            r_dgp <= {r_dgp[NQ-2:0], r_dg};

            for (int l = 0; l < NUM_LANES; l++) begin
                r_q[l] <= r_sgp[NQ-1][l] ? -$signed(QW'(w_quo[l])) : $signed(QW'(w_quo[l]));
            end
            r_dg_q <= r_dgp[NQ-1];

            for (int ax = 0; ax < 2; ax++) begin
                for (int h = 0; h < 2; h++) begin
                    r_s1[ax][h] <= SW'(r_q[4*h+ax]) + SW'(r_q[4*h+2+ax]);
                end
                r_s2[ax] <= r_s1[ax][0] + r_s1[ax][1];
                r_ng[ax] <= r_s2[ax][SW-1];
                r_mg[ax] <= $unsigned(r_s2[ax][SW-1] ? -r_s2[ax] : r_s2[ax]);
            end
            r_dg_s1 <= r_dg_q;
            r_dg_s2 <= r_dg_s1;
            r_dg_f1 <= r_dg_s2;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
        fat_div #(
            .NQ_BITS  (NQ),
            .DEN_BITS (DW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_dvd[l]),
            .i_den (r_dvs[l/2]),
            .o_quo (w_quo[l])
        );
    end

    // divide by four toward zero, saturate
    logic [EW-1:0]              w_sh  [2];
    logic [1:0]                 w_sat;
    logic signed [POS_BITS-1:0] w_pos [2];
    t_res                       w_res;

    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            w_sh[ax]  = EW'(r_mg[ax] >> 2);
            w_sat[ax] = r_ng[ax] ? (w_sh[ax] > LIM_N) : (w_sh[ax] > LIM_P);
            if (w_sat[ax]) begin
                w_pos[ax] = r_ng[ax] ? POS_MIN : POS_MAX;
            end else begin
                w_pos[ax] = r_ng[ax] ? $signed(~w_sh[ax][POS_BITS-1:0] + 32'd1)
                                     : $signed(w_sh[ax][POS_BITS-1:0]);
            end
        end
        w_res.pos_x      = r_dg_f1 ? '0 : w_pos[0];
        w_res.pos_y      = r_dg_f1 ? '0 : w_pos[1];
        w_res.degenerate = r_dg_f1;
        w_res.overflow   = ~r_dg_f1 & (|w_sat);
    end

    // output register and skid
    t_res r_o;
    t_res r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_k_v <= 1'b0;
        end else if (r_k_v) begin
            if (w_pop) begin
                r_o   <= r_k;
                r_k_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_o_v || w_pop) begin
                r_o   <= w_res;
                r_o_v <= 1'b1;
            end else begin
                r_k   <= w_res;
                r_k_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_o_v <= 1'b0;
        end
    end

    assign o_pos.valid      = r_o_v;
    assign o_pos.pos_x      = r_o.pos_x;
    assign o_pos.pos_y      = r_o.pos_y;
    assign o_pos.degenerate = r_o.degenerate;
    assign o_pos.overflow   = r_o.overflow;

endmodule

FILE: rtl/core/fat_chk.sv
// ----------------------------------------------------------------------------
// fat_chk
// Port-level checks on the position channel, bound to the top level.
// ----------------------------------------------------------------------------
module fat_chk
    import fat_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic signed [POS_BITS-1:0] i_pos_x,
    input logic signed [POS_BITS-1:0] i_pos_y,
    input logic                       i_degen,
    input logic                       i_ovf
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("position word dropped while stalled");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_degen |-> i_pos_x == '0 && i_pos_y == '0 && !i_ovf)
        else $error("degenerate word carries a position");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ovf |-> i_pos_x == POS_MAX || i_pos_x == POS_MIN
                          || i_pos_y == POS_MAX || i_pos_y == POS_MIN)
        else $error("overflow flag without a saturated position");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind four_anchor_trilateration fat_chk u_fat_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_pos.valid),
    .i_ready (o_pos.ready),
    .i_pos_x (o_pos.pos_x),
    .i_pos_y (o_pos.pos_y),
    .i_degen (o_pos.degenerate),
    .i_ovf   (o_pos.overflow)
);
